@@ rtl/tfr_pkg.sv @@
// Shared types, codes and helper functions for the telemetry frame receiver.
// No dependencies; imported by tfr_store, tfr_emit and the top level.
package tfr_pkg;

    localparam int MAX_PAYLOAD_DEF = 50;
    localparam int GPOS_W          = 5;     // width of payload positions read for gain words
    localparam int GAINS_PER_GROUP = 9;

    localparam logic [7:0] HDR0       = 8'hAA;
    localparam logic [7:0] HDR1       = 8'hAF;
    localparam logic [7:0] FUNC_LIMIT = 8'hF1;
    localparam logic [7:0] ACK_ID     = 8'hEF;
    localparam logic [7:0] ACK_LEN    = 8'h02;

    localparam logic [7:0] FN_READ    = 8'h02;
    localparam logic [7:0] FN_GAIN0   = 8'h10;
    localparam logic [7:0] FN_GAIN1   = 8'h11;
    localparam logic [7:0] FN_GAIN2   = 8'h12;
    localparam logic [7:0] FN_ACK0    = 8'h13;
    localparam logic [7:0] FN_ACK1    = 8'h14;
    localparam logic [7:0] FN_SAVE    = 8'h15;

    localparam logic [7:0] ARG_READBACK = 8'h01;
    localparam logic [7:0] ARG_RESTORE  = 8'hA1;

    localparam logic [1:0] KIND_GAIN  = 2'd0;
    localparam logic [1:0] KIND_ACK   = 2'd1;
    localparam logic [1:0] KIND_EVENT = 2'd2;

    localparam logic [1:0] EV_READBACK = 2'd0;
    localparam logic [1:0] EV_RESTORE  = 2'd1;
    localparam logic [1:0] EV_SAVE     = 2'd2;

    localparam logic [2:0] ACK_LAST_IDX = 3'd6;

    typedef logic [GPOS_W-1:0] t_gpos;

    typedef struct packed {
        logic       start;
        logic [7:0] func;
        logic [7:0] sum;
    } t_frame_cmd;

    typedef struct packed {
        logic  en;
        t_gpos pos_hi;
        t_gpos pos_lo;
    } t_rd_req;

    // One byte of the acknowledge frame AA AA EF 02 func sum check.
    function automatic logic [7:0] ack_byte(input logic [2:0] idx,
                                            input logic [7:0] fn,
                                            input logic [7:0] sum);
        logic [7:0] chk;
        chk = HDR0 + HDR0 + ACK_ID + ACK_LEN + fn + sum;
        case (idx)
            3'd0:    ack_byte = HDR0;
            3'd1:    ack_byte = HDR0;
            3'd2:    ack_byte = ACK_ID;
            3'd3:    ack_byte = ACK_LEN;
            3'd4:    ack_byte = fn;
            3'd5:    ack_byte = sum;
            default: ack_byte = chk;
        endcase
    endfunction

endpackage

@@ rtl/telemetry_frame_receiver_top.sv @@
// Telemetry frame receiver, top level: frame parser, payload store, result sequencer.
// Depends on tfr_pkg, tfr_store and tfr_emit.
//
// Input channel (i_in_valid / o_in_ready / i_rx_byte) takes one received byte per word.
// The parser hunts for AA AF func len payload sum; a byte that does not fit returns it
// to idle. Output channel (o_out_valid / i_out_ready) carries one result word at a time:
// gain words, acknowledge bytes or events, with o_last_of_run on the final word of a run.
// A byte that causes no result never holds the input; the next byte may follow at once.
// A good sum byte of a function with results starts the sequencer, and o_in_ready stays
// low until its last word is taken. Gain words pass through store read, load and
// hand-over; acknowledge bytes and the save event through load and hand-over; a
// read-back or restore event through store read, load and hand-over. A read request
// with an unknown argument holds the input over store read and load and emits nothing.
// A frame of function 10h/11h yields nine gain words and seven acknowledge bytes.
// A stall on the output side holds the current word and blocks further input bytes.
// Reset (synchronous, active low) returns the parser to idle, clears the store's valid
// bits so that unwritten payload positions read as zero, and drops o_out_valid.
module telemetry_frame_receiver_top #(
    parameter int MAX_PAYLOAD = tfr_pkg::MAX_PAYLOAD_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [7:0]         i_rx_byte,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [1:0]         o_kind,
    output logic [4:0]         o_gain_index,
    output logic signed [15:0] o_gain_value,
    output logic [7:0]         o_ack_byte,
    output logic [1:0]         o_event_code,
    output logic               o_last_of_run
);
    import tfr_pkg::*;

    localparam int CW = $clog2(MAX_PAYLOAD);

    localparam logic [2:0] P_IDLE = 3'd0;
    localparam logic [2:0] P_HDR1 = 3'd1;
    localparam logic [2:0] P_FUNC = 3'd2;
    localparam logic [2:0] P_LEN  = 3'd3;
    localparam logic [2:0] P_DATA = 3'd4;
    localparam logic [2:0] P_SUM  = 3'd5;

    logic [2:0]    r_pstate, n_pstate;
    logic [7:0]    r_func, n_func;
    logic [CW-1:0] r_left, n_left;
    logic [CW-1:0] r_count, n_count;
    logic [7:0]    r_sum, n_sum;

    logic       accept;
    logic       busy;
    logic       wr_en;
    logic       len_ok;
    logic [7:0] sum_add;
    t_frame_cmd cmd;
    t_rd_req    rd_req;
    logic [7:0] rd_hi;
    logic [7:0] rd_lo;

    assign o_in_ready = !busy;
    assign accept     = i_in_valid && o_in_ready;
    assign len_ok     = {1'b0, i_rx_byte} < 9'(MAX_PAYLOAD);
    assign sum_add    = r_sum + i_rx_byte;

    always_comb begin
        n_pstate  = r_pstate;
        n_func    = r_func;
        n_left    = r_left;
        n_count   = r_count;
        n_sum     = r_sum;
        wr_en     = 1'b0;
        cmd.start = 1'b0;
        cmd.func  = r_func;
        cmd.sum   = r_sum;
        if (accept) begin
            n_pstate = P_IDLE;
            case (r_pstate)
                P_IDLE: begin
                    if (i_rx_byte == HDR0) begin
                        n_pstate = P_HDR1;
                        n_sum    = i_rx_byte;
                    end
                end
                P_HDR1: begin
                    if (i_rx_byte == HDR1) begin
                        n_pstate = P_FUNC;
                        n_sum    = sum_add;
                    end
                end
                P_FUNC: begin
                    if (i_rx_byte < FUNC_LIMIT) begin
                        n_pstate = P_LEN;
                        n_func   = i_rx_byte;
                        n_sum    = sum_add;
                    end
                end
                P_LEN: begin
                    if (len_ok) begin
                        n_pstate = P_DATA;
                        n_left   = CW'(i_rx_byte);
                        n_count  = '0;
                        n_sum    = sum_add;
                    end
                end
                P_DATA: begin
                    // zero length falls through to idle
                    if (r_left != '0) begin
                        wr_en    = 1'b1;
                        n_count  = r_count + CW'(1);
                        n_left   = r_left - CW'(1);
                        n_sum    = sum_add;
                        n_pstate = (r_left == CW'(1)) ? P_SUM : P_DATA;
                    end
                end
                P_SUM: begin
                    // the sum byte lands in the store right after the payload
                    wr_en     = 1'b1;
                    cmd.start = (i_rx_byte == r_sum);
                end
                default: n_pstate = P_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pstate <= P_IDLE;
            r_func   <= 8'h00;
            r_left   <= '0;
            r_count  <= '0;
            r_sum    <= 8'h00;
        end else begin
            r_pstate <= n_pstate;
            r_func   <= n_func;
            r_left   <= n_left;
            r_count  <= n_count;
            r_sum    <= n_sum;
        end
    end

    tfr_store #(
        .MAX_PAYLOAD(MAX_PAYLOAD)
    ) u_store (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_wr_en  (wr_en),
        .i_wr_addr(r_count),
        .i_wr_data(i_rx_byte),
        .i_rd_req (rd_req),
        .o_rd_hi  (rd_hi),
        .o_rd_lo  (rd_lo)
    );

    tfr_emit u_emit (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_rd_req     (rd_req),
        .i_rd_hi      (rd_hi),
        .i_rd_lo      (rd_lo),
        .o_busy       (busy),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_kind       (o_kind),
        .o_gain_index (o_gain_index),
        .o_gain_value (o_gain_value),
        .o_ack_byte   (o_ack_byte),
        .o_event_code (o_event_code),
        .o_last_of_run(o_last_of_run)
    );

endmodule

@@ rtl/tfr_store.sv @@
// Payload store: one write port, two registered read ports, per-entry valid bits.
// Depends on tfr_pkg. Entries never written since reset read as zero.
module tfr_store #(
    parameter int MAX_PAYLOAD = tfr_pkg::MAX_PAYLOAD_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_wr_en,
    input  logic [$clog2(MAX_PAYLOAD)-1:0] i_wr_addr,
    input  logic [7:0]                     i_wr_data,
    input  tfr_pkg::t_rd_req               i_rd_req,
    output logic [7:0]                     o_rd_hi,
    output logic [7:0]                     o_rd_lo
);
    import tfr_pkg::*;

    localparam int AW = $clog2(MAX_PAYLOAD);
    localparam int PW = (AW > GPOS_W) ? AW : GPOS_W;

    logic [7:0]             r_mem [MAX_PAYLOAD];
    logic [MAX_PAYLOAD-1:0] r_vld;
    logic [7:0]             r_hi;
    logic [7:0]             r_lo;
    logic                   r_hi_ok;
    logic                   r_lo_ok;

    logic [PW-1:0] pos_hi_ext;
    logic [PW-1:0] pos_lo_ext;
    logic [AW-1:0] addr_hi;
    logic [AW-1:0] addr_lo;
    logic          ok_hi;
    logic          ok_lo;

    assign pos_hi_ext = PW'(i_rd_req.pos_hi);
    assign pos_lo_ext = PW'(i_rd_req.pos_lo);
    assign addr_hi    = pos_hi_ext[AW-1:0];
    assign addr_lo    = pos_lo_ext[AW-1:0];
    // positions at or past the store depth read as zero
    assign ok_hi      = 32'(i_rd_req.pos_hi) < MAX_PAYLOAD;
    assign ok_lo      = 32'(i_rd_req.pos_lo) < MAX_PAYLOAD;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_req.en && ok_hi) begin
            r_hi <= r_mem[addr_hi];
        end
        if (i_rd_req.en && ok_lo) begin
            r_lo <= r_mem[addr_lo];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld   <= '0;
            r_hi_ok <= 1'b0;
            r_lo_ok <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_vld[i_wr_addr] <= 1'b1;
            end
            if (i_rd_req.en) begin
                r_hi_ok <= ok_hi && r_vld[addr_hi];
                r_lo_ok <= ok_lo && r_vld[addr_lo];
            end
        end
    end

    assign o_rd_hi = r_hi_ok ? r_hi : 8'h00;
    assign o_rd_lo = r_lo_ok ? r_lo : 8'h00;

endmodule

@@ rtl/tfr_emit.sv @@
// Result sequencer: walks gain words, acknowledge bytes and events for a good frame.
// Depends on tfr_pkg; reads the payload store through a t_rd_req port.
module tfr_emit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  tfr_pkg::t_frame_cmd i_cmd,
    output tfr_pkg::t_rd_req    o_rd_req,
    input  logic [7:0]          i_rd_hi,
    input  logic [7:0]          i_rd_lo,
    output logic                o_busy,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic [1:0]          o_kind,
    output logic [4:0]          o_gain_index,
    output logic signed [15:0]  o_gain_value,
    output logic [7:0]          o_ack_byte,
    output logic [1:0]          o_event_code,
    output logic                o_last_of_run
);
    import tfr_pkg::*;

    localparam logic [1:0] E_IDLE = 2'd0;
    localparam logic [1:0] E_READ = 2'd1;
    localparam logic [1:0] E_LOAD = 2'd2;
    localparam logic [1:0] E_OUT  = 2'd3;

    localparam logic [1:0] PH_GAIN = 2'd0;
    localparam logic [1:0] PH_ACK  = 2'd1;
    localparam logic [1:0] PH_SAVE = 2'd2;
    localparam logic [1:0] PH_ARG  = 2'd3;

    logic [1:0] r_state, n_state;
    logic [1:0] r_phase, n_phase;
    logic [3:0] r_k, n_k;
    logic [7:0] r_func;
    logic [7:0] r_sum;
    logic       r_valid, n_valid;

    logic [1:0]         r_kind, n_kind;
    logic [4:0]         r_gidx, n_gidx;
    logic signed [15:0] r_gval, n_gval;
    logic [7:0]         r_ack, n_ack;
    logic [1:0]         r_ev, n_ev;
    logic               r_last, n_last;

    logic [3:0] gain_count;

    assign gain_count = (r_func == FN_GAIN2) ? 4'd6 : 4'(GAINS_PER_GROUP);

    // word k is big-endian at payload positions 2k and 2k+1
    assign o_rd_req.en     = (r_state == E_READ);
    assign o_rd_req.pos_hi = {r_k, 1'b0};
    assign o_rd_req.pos_lo = {r_k, 1'b1};

    always_comb begin
        n_state = r_state;
        n_phase = r_phase;
        n_k     = r_k;
        n_valid = r_valid;
        n_kind  = r_kind;
        n_gidx  = r_gidx;
        n_gval  = r_gval;
        n_ack   = r_ack;
        n_ev    = r_ev;
        n_last  = r_last;
        case (r_state)
            E_IDLE: begin
                if (i_cmd.start) begin
                    n_k = 4'd0;
                    case (i_cmd.func)
                        FN_GAIN0, FN_GAIN1, FN_GAIN2: begin
                            n_phase = PH_GAIN;
                            n_state = E_READ;
                        end
                        FN_ACK0, FN_ACK1, FN_SAVE: begin
                            n_phase = PH_ACK;
                            n_state = E_LOAD;
                        end
                        FN_READ: begin
                            n_phase = PH_ARG;
                            n_state = E_READ;
                        end
                        default: n_state = E_IDLE;
                    endcase
                end
            end
            E_READ: n_state = E_LOAD;
            E_LOAD: begin
                n_kind  = KIND_GAIN;
                n_gidx  = 5'd0;
                n_gval  = 16'sd0;
                n_ack   = 8'h00;
                n_ev    = EV_READBACK;
                n_last  = 1'b0;
                n_valid = 1'b1;
                n_state = E_OUT;
                case (r_phase)
                    PH_GAIN: begin
                        n_gidx = 5'(r_func[1:0]) * 5'(GAINS_PER_GROUP) + 5'(r_k);
                        n_gval = $signed({i_rd_hi, i_rd_lo});
                    end
                    PH_ACK: begin
                        n_kind = KIND_ACK;
                        n_ack  = ack_byte(r_k[2:0], r_func, r_sum);
                        n_last = (r_k[2:0] == ACK_LAST_IDX) && (r_func != FN_SAVE);
                    end
                    PH_SAVE: begin
                        n_kind = KIND_EVENT;
                        n_ev   = EV_SAVE;
                        n_last = 1'b1;
                    end
                    default: begin
                        n_kind = KIND_EVENT;
                        n_last = 1'b1;
                        if (i_rd_hi == ARG_READBACK) begin
                            n_ev = EV_READBACK;
                        end else if (i_rd_hi == ARG_RESTORE) begin
                            n_ev = EV_RESTORE;
                        end else begin
                            // unknown argument: nothing to report
                            n_valid = 1'b0;
                            n_state = E_IDLE;
                        end
                    end
                endcase
            end
            E_OUT: begin
                if (i_out_ready) begin
                    n_valid = 1'b0;
                    case (r_phase)
                        PH_GAIN: begin
                            if (r_k + 4'd1 < gain_count) begin
                                n_k     = r_k + 4'd1;
                                n_state = E_READ;
                            end else begin
                                n_k     = 4'd0;
                                n_phase = PH_ACK;
                                n_state = E_LOAD;
                            end
                        end
                        PH_ACK: begin
                            if (r_k[2:0] != ACK_LAST_IDX) begin
                                n_k     = r_k + 4'd1;
                                n_state = E_LOAD;
                            end else if (r_func == FN_SAVE) begin
                                n_phase = PH_SAVE;
                                n_state = E_LOAD;
                            end else begin
                                n_state = E_IDLE;
                            end
                        end
                        default: n_state = E_IDLE;
                    endcase
                end
            end
            default: n_state = E_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= E_IDLE;
            r_phase <= PH_GAIN;
            r_k     <= 4'd0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
            r_k     <= n_k;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == E_IDLE && i_cmd.start) begin
            r_func <= i_cmd.func;
            r_sum  <= i_cmd.sum;
        end
        r_kind <= n_kind;
        r_gidx <= n_gidx;
        r_gval <= n_gval;
        r_ack  <= n_ack;
        r_ev   <= n_ev;
        r_last <= n_last;
    end

    assign o_busy        = (r_state != E_IDLE);
    assign o_out_valid   = r_valid;
    assign o_kind        = r_kind;
    assign o_gain_index  = r_gidx;
    assign o_gain_value  = r_gval;
    assign o_ack_byte    = r_ack;
    assign o_event_code  = r_ev;
    assign o_last_of_run = r_last;

endmodule
